// ----- rtl/fpdb_pkg.sv -----
// Shared types and constants of the frame power dB meter.
// Holds the level threshold tables. No dependencies.
package fpdb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POWER_W  = 38;
  localparam int THR_W    = 40;
  localparam int LEVEL_W  = 7;
  localparam int DEC_W    = 4;
  localparam int FINE_W   = 4;
  localparam int DEC_N    = 12;
  localparam int FINE_N   = 9;

  // Finished frame handed from the accumulator to the level finder.
  typedef struct packed {
    logic               valid;
    logic [POWER_W-1:0] sum;
  } frame_t;

  // Frame after the decade search.
  typedef struct packed {
    logic               valid;
    logic               silent;
    logic [DEC_W-1:0]   decade;
    logic [POWER_W-1:0] sum;
  } decade_t;

  // Decade k is reached once power >= 10^k.
  localparam logic [THR_W-1:0] DECADE_THR [DEC_N] = '{
    40'd1,           40'd10,          40'd100,          40'd1000,
    40'd10000,       40'd100000,      40'd1000000,      40'd10000000,
    40'd100000000,   40'd1000000000,  40'd10000000000,  40'd100000000000
  };

  // Smallest power that reaches level 10*k + r, r = 1..9 (index r-1).
  localparam logic [THR_W-1:0] FINE_THR [DEC_N][FINE_N] = '{
    '{40'd2, 40'd2, 40'd2, 40'd3, 40'd4, 40'd4, 40'd6, 40'd7, 40'd8},
    '{40'd13, 40'd16, 40'd20, 40'd26, 40'd32, 40'd40, 40'd51, 40'd64, 40'd80},
    '{40'd126, 40'd159, 40'd200, 40'd252, 40'd317, 40'd399, 40'd502, 40'd631,
      40'd795},
    '{40'd1259, 40'd1585, 40'd1996, 40'd2512, 40'd3163, 40'd3982, 40'd5012,
      40'd6310, 40'd7944},
    '{40'd12590, 40'd15849, 40'd19953, 40'd25119, 40'd31623, 40'd39811,
      40'd50119, 40'd63096, 40'd79433},
    '{40'd125893, 40'd158490, 40'd199527, 40'd251189, 40'd316228, 40'd398108,
      40'd501188, 40'd630958, 40'd794329},
    '{40'd1258926, 40'd1584894, 40'd1995263, 40'd2511887, 40'd3162278,
      40'd3981072, 40'd5011873, 40'd6309574, 40'd7943283},
    '{40'd12589255, 40'd15848932, 40'd19952624, 40'd25118865, 40'd31622777,
      40'd39810718, 40'd50118724, 40'd63095735, 40'd79432824},
    '{40'd125892542, 40'd158489320, 40'd199526232, 40'd251188644,
      40'd316227767, 40'd398107171, 40'd501187234, 40'd630957345,
      40'd794328235},
    '{40'd1258925412, 40'd1584893193, 40'd1995262315, 40'd2511886432,
      40'd3162277661, 40'd3981071706, 40'd5011872337, 40'd6309573445,
      40'd7943282348},
    '{40'd12589254118, 40'd15848931925, 40'd19952623150, 40'd25118864316,
      40'd31622776602, 40'd39810717056, 40'd50118723363, 40'd63095734449,
      40'd79432823473},
    '{40'd125892541180, 40'd158489319247, 40'd199526231497, 40'd251188643151,
      40'd316227766017, 40'd398107170554, 40'd501187233628, 40'd630957344481,
      40'd794328234725}
  };

endpackage

// ----- rtl/frame_power_db_meter_core.sv -----
// Frame power dB meter: square, accumulate, and report floor(10*log10(power)).
// Path: the frame's last input word passes the input, frame, decade and output registers.
// Throughput: one input word per cycle; the whole pipe holds while the output
// word waits, so in_tready follows out_tready when a result is pending.
// Reset (rst_n low, synchronous) clears the accumulator and all valid flags.
// Instantiates fpdb_accum and fpdb_level; uses fpdb_pkg.
module frame_power_db_meter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] level_db, [7] zero
  output logic [0:0]  out_tuser   // [0] silent
);

  fpdb_pkg::frame_t               frame;
  logic                           en;
  logic                           out_valid;
  logic [fpdb_pkg::LEVEL_W-1:0]   out_level;
  logic                           out_silent;

  assign en        = !out_valid || out_tready;
  assign in_tready = en;

  fpdb_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_sample (in_tdata),
    .in_last   (in_tlast),
    .frame_o   (frame)
  );

  fpdb_level u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .frame_i    (frame),
    .out_valid  (out_valid),
    .out_level  (out_level),
    .out_silent (out_silent)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {1'b0, out_level};
  assign out_tuser  = out_silent;

endmodule

// ----- rtl/fpdb_accum.sv -----
// Input register and saturating frame power accumulator.
// Uses fpdb_pkg.
module fpdb_accum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [fpdb_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                             in_last,
  output fpdb_pkg::frame_t                 frame_o
);

  localparam int SQ_W   = 2 * fpdb_pkg::SAMPLE_W;
  localparam int TERM_W = SQ_W - 3;

  logic                             s1_valid_r;
  logic [fpdb_pkg::SAMPLE_W-1:0]    s1_sample_r;
  logic                             s1_last_r;
  logic [fpdb_pkg::POWER_W-1:0]     power_sum_r, power_sum_nxt;
  fpdb_pkg::frame_t                 frame_r, frame_nxt;

  logic [fpdb_pkg::SAMPLE_W-1:0]    mag;
  logic [SQ_W-1:0]                  square;
  logic [TERM_W-1:0]                term;
  logic [fpdb_pkg::POWER_W:0]       sum_ext;
  logic [fpdb_pkg::POWER_W-1:0]     sum_sat;

  always_comb begin
    // -32768 gives magnitude 0x8000, which still fits unsigned
    mag     = s1_sample_r[fpdb_pkg::SAMPLE_W-1] ? (~s1_sample_r + 1'b1) : s1_sample_r;
    square  = SQ_W'(mag) * SQ_W'(mag);
    term    = square[SQ_W-1:3];
    sum_ext = {1'b0, power_sum_r} + {{(fpdb_pkg::POWER_W+1-TERM_W){1'b0}}, term};
    sum_sat = sum_ext[fpdb_pkg::POWER_W] ? {fpdb_pkg::POWER_W{1'b1}}
                                          : sum_ext[fpdb_pkg::POWER_W-1:0];

    power_sum_nxt   = power_sum_r;
    frame_nxt.valid = 1'b0;
    frame_nxt.sum   = sum_sat;
    if (s1_valid_r) begin
      if (s1_last_r) begin
        power_sum_nxt   = '0;
        frame_nxt.valid = 1'b1;
      end else begin
        power_sum_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      power_sum_r <= '0;
      frame_r     <= '0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      power_sum_r <= power_sum_nxt;
      frame_r     <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
  end

  assign frame_o = frame_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s1_valid_r && s1_last_r) |=> (power_sum_r == '0) && frame_r.valid)
    else $error("accumulator not cleared after frame end");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !s1_valid_r) |=> $stable(power_sum_r) && !frame_r.valid)
    else $error("accumulator moved without a sample");

endmodule

// ----- rtl/fpdb_level.sv -----
// Two-stage dB level search: decade compare, then fine compare in decade.
// Uses fpdb_pkg threshold tables; drives the output register.
module fpdb_level (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  fpdb_pkg::frame_t                 frame_i,
  output logic                             out_valid,
  output logic [fpdb_pkg::LEVEL_W-1:0]     out_level,
  output logic                             out_silent
);

  fpdb_pkg::decade_t                  dec_r, dec_nxt;
  logic                               out_valid_r;
  logic [fpdb_pkg::LEVEL_W-1:0]       out_level_r, level_nxt;
  logic                               out_silent_r;
  logic [fpdb_pkg::THR_W-1:0]         sum_a, sum_b;
  logic [fpdb_pkg::FINE_W-1:0]        fine;
  logic [fpdb_pkg::LEVEL_W-1:0]       dec_ext;

  always_comb begin
    sum_a = {{(fpdb_pkg::THR_W-fpdb_pkg::POWER_W){1'b0}}, frame_i.sum};
    dec_nxt.valid  = frame_i.valid;
    dec_nxt.silent = (frame_i.sum == '0);
    dec_nxt.sum    = frame_i.sum;
    dec_nxt.decade = '0;
    for (int k = 1; k < fpdb_pkg::DEC_N; k++) begin
      if (sum_a >= fpdb_pkg::DECADE_THR[k]) dec_nxt.decade = dec_nxt.decade + 1'b1;
    end
  end

  always_comb begin
    sum_b = {{(fpdb_pkg::THR_W-fpdb_pkg::POWER_W){1'b0}}, dec_r.sum};
    fine  = '0;
    for (int r = 0; r < fpdb_pkg::FINE_N; r++) begin
      if (sum_b >= fpdb_pkg::FINE_THR[dec_r.decade][r]) fine = fine + 1'b1;
    end
    dec_ext   = {{(fpdb_pkg::LEVEL_W-fpdb_pkg::DEC_W){1'b0}}, dec_r.decade};
    // level = 10 * decade + fine step
    level_nxt = (dec_ext << 3) + (dec_ext << 1)
              + {{(fpdb_pkg::LEVEL_W-fpdb_pkg::FINE_W){1'b0}}, fine};
    if (dec_r.silent) level_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dec_r       <= dec_nxt;
      out_valid_r <= dec_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_level_r  <= level_nxt;
      out_silent_r <= dec_r.silent;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_silent = out_silent_r;

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_silent_r) |-> (out_level_r == '0))
    else $error("silent frame with nonzero level");

  a_level_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_level_r <= 7'd114))
    else $error("level above full scale");

  a_decade_range: assert property (@(posedge clk) disable iff (!rst_n)
    dec_r.valid |-> (dec_r.decade < 4'd12) && (dec_r.silent == (dec_r.sum == '0)))
    else $error("decade stage inconsistent");

endmodule
